// ===== src/fvcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fvcc_pkg
// Shared types, constants and the color wheel table of the flow color coder.
// ----------------------------------------------------------------------------
package fvcc_pkg;

  localparam int FLOW_BITS    = 16;
  localparam int SUM_W        = 2 * FLOW_BITS;
  localparam int ANG_W        = 16;
  localparam int RATIO_FRAC   = 16;
  localparam int PRESCALE     = 20;
  localparam int CORDIC_STEPS = 14;
  localparam int WHEEL_LEN    = 55;
  localparam int XY_W         = FLOW_BITS + PRESCALE + 4;

  typedef struct packed {
    logic                        action;
    logic                        frame_start;
    logic                        unknown;
    logic signed [FLOW_BITS-1:0] flow_x;
    logic signed [FLOW_BITS-1:0] flow_y;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam logic signed [15:0] ATAN_TAB [CORDIC_STEPS] = '{
    16'sd8192, 16'sd4836, 16'sd2555, 16'sd1297, 16'sd651, 16'sd326, 16'sd163,
    16'sd81, 16'sd41, 16'sd20, 16'sd10, 16'sd5, 16'sd3, 16'sd1
  };

  // red, green, blue per wheel entry
  localparam logic [23:0] WHEEL [WHEEL_LEN] = '{
    {8'd255, 8'd0, 8'd0}, {8'd255, 8'd17, 8'd0}, {8'd255, 8'd34, 8'd0},
    {8'd255, 8'd51, 8'd0}, {8'd255, 8'd68, 8'd0}, {8'd255, 8'd85, 8'd0},
    {8'd255, 8'd102, 8'd0}, {8'd255, 8'd119, 8'd0}, {8'd255, 8'd136, 8'd0},
    {8'd255, 8'd153, 8'd0}, {8'd255, 8'd170, 8'd0}, {8'd255, 8'd187, 8'd0},
    {8'd255, 8'd204, 8'd0}, {8'd255, 8'd221, 8'd0}, {8'd255, 8'd238, 8'd0},
    {8'd255, 8'd255, 8'd0}, {8'd213, 8'd255, 8'd0}, {8'd170, 8'd255, 8'd0},
    {8'd128, 8'd255, 8'd0}, {8'd85, 8'd255, 8'd0}, {8'd43, 8'd255, 8'd0},
    {8'd0, 8'd255, 8'd0}, {8'd0, 8'd255, 8'd63}, {8'd0, 8'd255, 8'd127},
    {8'd0, 8'd255, 8'd191},
    {8'd0, 8'd255, 8'd255}, {8'd0, 8'd232, 8'd255}, {8'd0, 8'd209, 8'd255},
    {8'd0, 8'd186, 8'd255}, {8'd0, 8'd163, 8'd255}, {8'd0, 8'd140, 8'd255},
    {8'd0, 8'd116, 8'd255}, {8'd0, 8'd93, 8'd255}, {8'd0, 8'd70, 8'd255},
    {8'd0, 8'd47, 8'd255}, {8'd0, 8'd24, 8'd255},
    {8'd0, 8'd0, 8'd255}, {8'd19, 8'd0, 8'd255}, {8'd39, 8'd0, 8'd255},
    {8'd58, 8'd0, 8'd255}, {8'd78, 8'd0, 8'd255}, {8'd98, 8'd0, 8'd255},
    {8'd117, 8'd0, 8'd255}, {8'd137, 8'd0, 8'd255}, {8'd156, 8'd0, 8'd255},
    {8'd176, 8'd0, 8'd255}, {8'd196, 8'd0, 8'd255}, {8'd215, 8'd0, 8'd255},
    {8'd235, 8'd0, 8'd255},
    {8'd255, 8'd0, 8'd255}, {8'd255, 8'd0, 8'd213}, {8'd255, 8'd0, 8'd170},
    {8'd255, 8'd0, 8'd128}, {8'd255, 8'd0, 8'd85}, {8'd255, 8'd0, 8'd43}
  };

  function automatic logic [23:0] wheel_color(input logic [5:0] k);
    logic [23:0] c;
    if (k < 6'(WHEEL_LEN)) begin
      c = WHEEL[k];
    end else begin
      c = WHEEL[WHEEL_LEN-1];
    end
    return c;
  endfunction

endpackage

// ===== src/fvcc_root.sv =====
// ----------------------------------------------------------------------------
// fvcc_root
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fvcc_root (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [fvcc_pkg::SUM_W-1:0]      radicand,
  output fvcc_pkg::unit_stat_t            stat,
  output logic [fvcc_pkg::FLOW_BITS-1:0]  root
);

  localparam int W     = fvcc_pkg::SUM_W;
  localparam int STEPS = W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [W-1:0]     rem;
  logic [W-1:0]     acc;
  logic [W-1:0]     bitm;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [W-1:0]     trial;

  assign trial = acc + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= radicand;
        acc  <= '0;
        bitm <= W'(1) << (W - 2);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitm;
        end else begin
          acc <= acc >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};
  assign root = acc[fvcc_pkg::FLOW_BITS-1:0];

endmodule

// ===== src/fvcc_divide.sv =====
// ----------------------------------------------------------------------------
// fvcc_divide
// Restoring divider for radius over maximum radius, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fvcc_divide (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [fvcc_pkg::FLOW_BITS-1:0]   num,
  input  logic [fvcc_pkg::FLOW_BITS-1:0]   den,
  output fvcc_pkg::unit_stat_t             stat,
  output logic [fvcc_pkg::RATIO_FRAC:0]    ratio,
  output logic                             over
);

  localparam int F     = fvcc_pkg::FLOW_BITS;
  localparam int Q     = fvcc_pkg::RATIO_FRAC;
  localparam int CNT_W = $clog2(Q);

  logic [F-1:0]     den_q;
  logic [F:0]       rem;
  logic [Q-1:0]     quo;
  logic             zero_q;
  logic             eq_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [F+1:0]     sh;
  logic             ge;

  assign sh = {rem, 1'b0};
  assign ge = sh >= {2'b00, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        den_q  <= den;
        rem    <= {1'b0, num};
        quo    <= '0;
        zero_q <= (den == '0);
        eq_q   <= (num == den);
        over   <= (den != '0) && (num > den);
      end else if (busy) begin
        rem <= ge ? (F+1)'(sh - {2'b00, den_q}) : sh[F:0];
        quo <= {quo[Q-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(Q - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero_q) begin
      ratio = '0;
    end else if (eq_q) begin
      ratio = (Q+1)'(1) << Q;
    end else begin
      ratio = {1'b0, quo};
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

// ===== src/fvcc_cordic.sv =====
// ----------------------------------------------------------------------------
// fvcc_cordic
// Vectoring cordic on the first octant, one rotation a cycle, then unfolded
// to a binary angle over the full circle.
// ----------------------------------------------------------------------------
module fvcc_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [fvcc_pkg::FLOW_BITS-1:0] fx,
  input  logic signed [fvcc_pkg::FLOW_BITS-1:0] fy,
  output fvcc_pkg::unit_stat_t                  stat,
  output logic [fvcc_pkg::ANG_W-1:0]            angle
);

  localparam int F     = fvcc_pkg::FLOW_BITS;
  localparam int W     = fvcc_pkg::XY_W;
  localparam int STEPS = fvcc_pkg::CORDIC_STEPS;
  localparam int CNT_W = $clog2(STEPS);

  logic signed [W-1:0] xr;
  logic signed [W-1:0] yr;
  logic signed [15:0]  z;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic                xneg;
  logic                yneg;
  logic                swapped;
  logic [F-1:0]        ax;
  logic [F-1:0]        ay;
  logic [F-1:0]        big;
  logic [F-1:0]        lit;
  logic [13:0]         zc;
  logic [14:0]         zs;
  logic [16:0]         t;

  assign ax  = fx[F-1] ? F'(-fx) : F'(fx);
  assign ay  = fy[F-1] ? F'(-fy) : F'(fy);
  assign big = (ay > ax) ? ay : ax;
  assign lit = (ay > ax) ? ax : ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        z       <= '0;
        xneg    <= fx[F-1];
        yneg    <= fy[F-1];
        swapped <= ay > ax;
        xr      <= signed'({{(W-F){1'b0}}, big}) <<< fvcc_pkg::PRESCALE;
        yr      <= signed'({{(W-F){1'b0}}, lit}) <<< fvcc_pkg::PRESCALE;
      end else if (busy) begin
        if (yr > 0) begin
          xr <= xr + (yr >>> cnt);
          yr <= yr - (xr >>> cnt);
          z  <= z + fvcc_pkg::ATAN_TAB[cnt];
        end else begin
          xr <= xr - (yr >>> cnt);
          yr <= yr + (xr >>> cnt);
          z  <= z - fvcc_pkg::ATAN_TAB[cnt];
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (z < 0) begin
      zc = '0;
    end else if (z > 16'sd8192) begin
      zc = 14'd8192;
    end else begin
      zc = z[13:0];
    end
    zs = swapped ? 15'd16384 - {1'b0, zc} : {1'b0, zc};
    case ({xneg, yneg})
      2'b00:   t = {2'b00, zs};
      2'b10:   t = 17'd32768 - {2'b00, zs};
      2'b11:   t = 17'd32768 + {2'b00, zs};
      default: t = 17'd65536 - {2'b00, zs};
    endcase
  end

  assign angle = t[fvcc_pkg::ANG_W-1:0];
  assign stat  = '{busy: busy, done: done};

endmodule

// ===== src/fvcc_blend.sv =====
// ----------------------------------------------------------------------------
// fvcc_blend
// Wheel lookup, blend and saturation, one channel at a time: a blend phase, then a saturation phase.
// ----------------------------------------------------------------------------
module fvcc_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [fvcc_pkg::ANG_W-1:0]      angle,
  input  logic [fvcc_pkg::RATIO_FRAC:0]   ratio,
  input  logic                            over,
  output fvcc_pkg::unit_stat_t            stat,
  output fvcc_pkg::out_t                  color
);

  localparam int RW = fvcc_pkg::RATIO_FRAC + 1;

  logic [23:0]   c0;
  logic [23:0]   c1;
  logic [15:0]   frac;
  logic [RW-1:0] ratio_q;
  logic          over_q;
  logic [1:0]    ch;
  logic          phase;
  logic [23:0]   creg;
  logic          busy;
  logic          done;
  logic [21:0]   wpos;
  logic [5:0]    k0;
  logic [5:0]    k1;
  logic [7:0]    b0;
  logic [7:0]    b1;
  logic [24:0]   mix;
  logic [23:0]   dd;
  logic [41:0]   prod;
  logic [41:0]   pr;
  logic [9:0]    pv;
  logic [7:0]    vin;
  logic [25:0]   o3;
  logic [7:0]    val;

  function automatic logic [7:0] chan(input logic [23:0] c, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = c[23:16];
      2'd1:    r = c[15:8];
      default: r = c[7:0];
    endcase
    return r;
  endfunction

  assign wpos = 22'(angle) * 22'(fvcc_pkg::WHEEL_LEN - 1);
  assign k0   = wpos[21:16];
  assign k1   = (k0 == 6'(fvcc_pkg::WHEEL_LEN - 1)) ? 6'd0 : k0 + 6'd1;

  assign b0  = chan(c0, ch);
  assign b1  = chan(c1, ch);
  assign mix = 25'(b0) * (25'h10000 - 25'(frac)) + 25'(b1) * 25'(frac);

  assign dd   = 24'd16711680 - creg;
  assign prod = 42'(ratio_q) * 42'(dd);
  assign pr   = prod + 42'h0_FFFF_FFFF;
  assign pv   = pr[41:32];
  assign vin  = (pv > 10'd255) ? 8'd0 : 8'(10'd255 - pv);
  assign o3   = 26'(creg) * 26'd3;
  assign val  = over_q ? o3[25:18] : vin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        ch      <= 2'd0;
        phase   <= 1'b0;
        c0      <= fvcc_pkg::wheel_color(k0);
        c1      <= fvcc_pkg::wheel_color(k1);
        frac    <= wpos[15:0];
        ratio_q <= ratio;
        over_q  <= over;
      end else if (busy) begin
        phase <= ~phase;
        if (!phase) begin
          creg <= mix[23:0];
        end else begin
          case (ch)
            2'd0:    color.red   <= val;
            2'd1:    color.green <= val;
            default: color.blue  <= val;
          endcase
          ch <= ch + 2'd1;
          if (ch == 2'd2) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

// ===== src/flow_vector_color_coder_top.sv =====
// ----------------------------------------------------------------------------
// flow_vector_color_coder_top
// Optical-flow color wheel coder with a measure pass and a paint pass.
// ----------------------------------------------------------------------------
// One word is worked on at a time; item_ready is high only while idle. A
// measure word passes two states on the shared squaring multiplier (x,
// then y) and the bit-serial square root (16 steps and a done strobe). A
// paint word then also waits on the 16-step divider and the 14-step
// cordic, run side by side, and on the blend unit (a blend and a
// saturation phase per channel), then loads the output register once it
// is free. An unknown vector skips the units: measured, it leaves the block
// idle; painted, it goes straight to the hold state with a zero color. The
// output register lets the next word in while a color still waits to be
// taken; a color that is ready while the previous one is still held waits
// in the hold state until the register is free.
module flow_vector_color_coder_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  fvcc_pkg::in_t  item,
  output logic           color_valid,
  input  logic           color_ready,
  output fvcc_pkg::out_t color
);

  localparam int F = fvcc_pkg::FLOW_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQX   = 7'b0000010,
    S_SQY   = 7'b0000100,
    S_ROOT  = 7'b0001000,
    S_ARC   = 7'b0010000,
    S_SHADE = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_t;

  state_t                      state;
  fvcc_pkg::in_t               word;
  logic [fvcc_pkg::SUM_W-1:0]  sumsq;
  logic [F-1:0]                max_radius;
  logic                        div_seen;
  logic                        cordic_seen;

  logic                        accept;
  logic signed [F-1:0]         mul_op;
  logic signed [2*F-1:0]       sq;
  logic [fvcc_pkg::SUM_W-1:0]  radicand;
  logic                        root_start;
  logic                        arc_start;
  logic                        blend_start;
  logic                        load;
  logic [F-1:0]                root_val;
  logic [fvcc_pkg::RATIO_FRAC:0] ratio;
  logic                        over;
  logic [fvcc_pkg::ANG_W-1:0]  angle;
  fvcc_pkg::out_t              blend_color;
  fvcc_pkg::unit_stat_t        root_stat;
  fvcc_pkg::unit_stat_t        div_stat;
  fvcc_pkg::unit_stat_t        cordic_stat;
  fvcc_pkg::unit_stat_t        blend_stat;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  // shared squaring multiplier
  assign mul_op   = (state == S_SQX) ? word.flow_x : word.flow_y;
  assign sq       = mul_op * mul_op;
  assign radicand = sumsq + fvcc_pkg::SUM_W'(sq);

  assign root_start  = (state == S_SQY);
  assign arc_start   = (state == S_ROOT) && root_stat.done && word.action;
  assign blend_start = (state == S_ARC) && (div_seen || div_stat.done)
                       && (cordic_seen || cordic_stat.done);
  assign load        = (state == S_HOLD) && (!color_valid || color_ready);

  fvcc_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .stat     (root_stat),
    .root     (root_val)
  );

  fvcc_divide u_divide (
    .clk   (clk),
    .rst   (rst),
    .start (arc_start),
    .num   (root_val),
    .den   (max_radius),
    .stat  (div_stat),
    .ratio (ratio),
    .over  (over)
  );

  fvcc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (arc_start),
    .fx    (word.flow_x),
    .fy    (word.flow_y),
    .stat  (cordic_stat),
    .angle (angle)
  );

  fvcc_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (blend_start),
    .angle (angle),
    .ratio (ratio),
    .over  (over),
    .stat  (blend_stat),
    .color (blend_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_radius  <= '0;
      div_seen    <= 1'b0;
      cordic_seen <= 1'b0;
      color_valid <= 1'b0;
    end else begin
      if (load) begin
        color_valid <= 1'b1;
        color       <= word.unknown ? '0 : blend_color;
      end else if (color_ready) begin
        color_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            word <= item;
            if (!item.action && item.frame_start) begin
              max_radius <= '0;
            end
            if (!item.unknown) begin
              state <= S_SQX;
            end else if (item.action) begin
              state <= S_HOLD;
            end
          end
        end
        S_SQX: begin
          sumsq <= fvcc_pkg::SUM_W'(sq);
          state <= S_SQY;
        end
        S_SQY: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_stat.done) begin
            if (word.action) begin
              div_seen    <= 1'b0;
              cordic_seen <= 1'b0;
              state       <= S_ARC;
            end else begin
              if (root_val > max_radius) begin
                max_radius <= root_val;
              end
              state <= S_IDLE;
            end
          end
        end
        S_ARC: begin
          if (div_stat.done) begin
            div_seen <= 1'b1;
          end
          if (cordic_stat.done) begin
            cordic_seen <= 1'b1;
          end
          if (blend_start) begin
            state <= S_SHADE;
          end
        end
        S_SHADE: begin
          if (blend_stat.done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no new word while any unit is still working
  assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !(root_stat.busy || div_stat.busy || cordic_stat.busy
                     || blend_stat.busy))
    else $error("word accepted while a unit is busy");

  // the blend only starts once both angle and ratio are final
  assert property (@(posedge clk) disable iff (rst)
    blend_start |-> !div_stat.busy && !cordic_stat.busy)
    else $error("blend started before divider and cordic finished");

  // the root of a measure word never lowers the maximum; a frame start clears it on accept
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) && root_stat.done && !word.action
      |=> max_radius >= $past(max_radius))
    else $error("maximum radius decreased on a measure word");

  // a color is only loaded from the hold state
  assert property (@(posedge clk) disable iff (rst)
    $rose(color_valid) |-> $past(state == S_HOLD))
    else $error("color loaded outside the hold state");

endmodule
